>>> rtl/indexed_insert_remove_array_assert.svh
// Assertion macros shared by the indexed insert and remove array.
`ifndef INDEXED_INSERT_REMOVE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define IIRA_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IIRA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/iira_pkg.sv
// Types, codes and sizes shared by the indexed insert and remove array.
`timescale 1ns / 1ps

package iira_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int DATA_W    = 32;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] data_in;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [1:0]               status;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_out;

    typedef struct packed {
        logic [1:0]               op;
        logic [IDX_W-1:0]         pos;
        logic [IDX_W-1:0]         rd_pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

>>> rtl/iira_cell.sv
// One storage cell of the array: holds one entry and shifts with its neighbours.
`timescale 1ns / 1ps

module iira_cell (
    input  logic                                 i_clk,
    input  logic [iira_pkg::IDX_W-1:0]           i_index,
    input  iira_pkg::t_cell_cmd                  i_cmd,
    input  logic signed [iira_pkg::DATA_W-1:0]   i_left,
    input  logic signed [iira_pkg::DATA_W-1:0]   i_right,
    output logic signed [iira_pkg::DATA_W-1:0]   o_entry,
    output logic signed [iira_pkg::DATA_W-1:0]   o_rd_data
);

    logic signed [iira_pkg::DATA_W-1:0] r_entry;
    logic signed [iira_pkg::DATA_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            iira_pkg::CELL_INSERT: begin
                if (i_index == i_cmd.pos) begin
                    n_entry = i_cmd.value;
                end else if (i_index > i_cmd.pos) begin
                    n_entry = i_left;
                end
            end
            iira_pkg::CELL_REMOVE: begin
                if (i_index >= i_cmd.pos) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry   = r_entry;
    assign o_rd_data = (i_index == i_cmd.rd_pos) ? r_entry : '0;

endmodule

>>> rtl/indexed_insert_remove_array.sv
// Top level of the indexed insert and remove array: control, cell row and result register.
`timescale 1ns / 1ps
//
//  Channel  | Valid   | Ready   | Payload
//  ---------+---------+---------+---------------------------------------
//  input    | i_valid | o_ready | i_data (opcode, position, data_in)
//  output   | o_valid | i_ready | o_data (data_out, status, entry_count)
//
// One item is accepted per cycle while o_ready is high; its result is then registered.
// Every cell of the row updates on the same edge, so insert and remove shift the row at once.
// Reset clears the entry count and the output valid; entries are not cleared.
// The input is stalled only while a result waits in the output register and is not taken.

module indexed_insert_remove_array (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  iira_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output iira_pkg::t_out o_data
);

    `include "indexed_insert_remove_array_assert.svh"

    logic [iira_pkg::CNT_W-1:0] r_count;
    logic [iira_pkg::CNT_W-1:0] n_count;
    logic                       r_out_valid;
    iira_pkg::t_out             r_out;
    iira_pkg::t_out             n_out;
    logic [1:0]                 n_status;
    iira_pkg::t_cell_cmd        cmd;
    logic                       in_fire;
    logic                       full;
    logic [iira_pkg::CMP_W-1:0] pos_x;
    logic [iira_pkg::CMP_W-1:0] cnt_x;
    logic [iira_pkg::IDX_W-1:0] last_idx;
    logic signed [iira_pkg::DATA_W-1:0] rd_data;

    logic signed [iira_pkg::DATA_W-1:0] cell_entry [iira_pkg::CAPACITY];
    logic signed [iira_pkg::DATA_W-1:0] cell_rd    [iira_pkg::CAPACITY];

    assign o_ready  = !r_out_valid || i_ready;
    assign in_fire  = i_valid && o_ready;
    assign full     = (r_count >= iira_pkg::CNT_W'(iira_pkg::CAPACITY));
    assign pos_x    = iira_pkg::CMP_W'(i_data.position);
    assign cnt_x    = iira_pkg::CMP_W'(r_count);
    assign last_idx = iira_pkg::IDX_W'(r_count - 1'b1);

    always_comb begin
        logic [1:0] op;
        op         = iira_pkg::CELL_HOLD;
        n_status   = iira_pkg::ST_OK;
        n_count    = r_count;
        cmd.pos    = iira_pkg::IDX_W'(pos_x);
        cmd.rd_pos = iira_pkg::IDX_W'(pos_x);
        cmd.value  = i_data.data_in;
        unique case (i_data.opcode)
            iira_pkg::OP_APPEND: begin
                cmd.pos = iira_pkg::IDX_W'(r_count);
                if (full) begin
                    n_status = iira_pkg::ST_FULL;
                end else begin
                    op      = iira_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            iira_pkg::OP_INSERT: begin
                if (pos_x > cnt_x) begin
                    n_status = iira_pkg::ST_BAD_INDEX;
                end else if (full) begin
                    n_status = iira_pkg::ST_FULL;
                end else begin
                    op      = iira_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            iira_pkg::OP_REMOVE: begin
                if (r_count == '0) begin
                    n_status = iira_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    n_status = iira_pkg::ST_BAD_INDEX;
                end else begin
                    op      = iira_pkg::CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            iira_pkg::OP_READ: begin
                if (r_count == '0) begin
                    n_status = iira_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    cmd.rd_pos = last_idx;
                end
            end
            default: begin
                n_status = iira_pkg::ST_OK;
            end
        endcase
        cmd.op = in_fire ? op : iira_pkg::CELL_HOLD;
    end

    for (genvar g = 0; g < iira_pkg::CAPACITY; g++) begin : g_cell
        logic signed [iira_pkg::DATA_W-1:0] left;
        logic signed [iira_pkg::DATA_W-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_inner_l
            assign left = cell_entry[g-1];
        end
        if (g == iira_pkg::CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner_r
            assign right = cell_entry[g+1];
        end
        iira_cell u_cell (
            .i_clk     (i_clk),
            .i_index   (iira_pkg::IDX_W'(g)),
            .i_cmd     (cmd),
            .i_left    (left),
            .i_right   (right),
            .o_entry   (cell_entry[g]),
            .o_rd_data (cell_rd[g])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < iira_pkg::CAPACITY; k++) begin
            rd_data = rd_data | cell_rd[k];
        end
    end

    always_comb begin
        n_out.status      = n_status;
        n_out.entry_count = iira_pkg::CNT_OUT_W'(n_count);
        n_out.data_out    = '0;
        if ((i_data.opcode == iira_pkg::OP_READ) && (n_status == iira_pkg::ST_OK)) begin
            n_out.data_out = rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `IIRA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= iira_pkg::CNT_W'(iira_pkg::CAPACITY), "entry count exceeds capacity")
    `IIRA_ASSERT_NEXT(a_grow_by_one, i_clk, i_rst_n,
        in_fire && (n_status == iira_pkg::ST_OK) && ((i_data.opcode == iira_pkg::OP_APPEND) ||
        (i_data.opcode == iira_pkg::OP_INSERT)),
        r_count == $past(r_count) + 1'b1, "successful append or insert did not grow the count")
    `IIRA_ASSERT_NOW(a_empty_count, i_clk, i_rst_n,
        o_valid && (o_data.status == iira_pkg::ST_EMPTY),
        o_data.entry_count == '0, "empty status with a nonzero count")
    `IIRA_ASSERT_NOW(a_refused_zero, i_clk, i_rst_n,
        o_valid && (o_data.status != iira_pkg::ST_OK),
        o_data.data_out == '0, "refused item carries nonzero data")

endmodule

>>> test/tb.sv
// Testbench for the indexed insert and remove array: stimulus, list prediction and result checks.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CALM_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    iira_pkg::t_in  i_data;
    logic           o_valid;
    logic           i_ready;
    iira_pkg::t_out o_data;

    indexed_insert_remove_array dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    iira_pkg::t_in  pending_ops[$];
    iira_pkg::t_out expected_results[$];

    logic signed [iira_pkg::DATA_W-1:0] list_words[iira_pkg::CAPACITY];
    int list_len;
    int gen_len;
    int max_len_seen;
    int fail_count;
    int report_count;
    int ops_taken;
    int results_seen;
    int status_seen[4];
    int cycle_count;
    int drv_gap;
    int snk_gap;
    bit op_fire;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic iira_pkg::t_out apply_list_op(input iira_pkg::t_in op);
        iira_pkg::t_out res;
        int k;
        res = '0;
        res.status = iira_pkg::ST_OK;
        case (op.opcode)
            iira_pkg::OP_APPEND: begin
                if (list_len >= iira_pkg::CAPACITY) begin
                    res.status = iira_pkg::ST_FULL;
                end else begin
                    list_words[list_len] = op.data_in;
                    list_len++;
                end
            end
            iira_pkg::OP_INSERT: begin
                if (int'(op.position) > list_len) begin
                    res.status = iira_pkg::ST_BAD_INDEX;
                end else if (list_len >= iira_pkg::CAPACITY) begin
                    res.status = iira_pkg::ST_FULL;
                end else begin
                    for (k = list_len; k > int'(op.position); k--) begin
                        list_words[k] = list_words[k-1];
                    end
                    list_words[iira_pkg::IDX_W'(op.position)] = op.data_in;
                    list_len++;
                end
            end
            iira_pkg::OP_REMOVE: begin
                if (list_len == 0) begin
                    res.status = iira_pkg::ST_EMPTY;
                end else if (int'(op.position) >= list_len) begin
                    res.status = iira_pkg::ST_BAD_INDEX;
                end else begin
                    for (k = int'(op.position); k + 1 < list_len; k++) begin
                        list_words[k] = list_words[k+1];
                    end
                    list_words[list_len-1] = '0;
                    list_len--;
                end
            end
            default: begin
                if (list_len == 0) begin
                    res.status = iira_pkg::ST_EMPTY;
                end else if (int'(op.position) >= list_len) begin
                    res.data_out = list_words[list_len-1];
                end else begin
                    res.data_out = list_words[iira_pkg::IDX_W'(op.position)];
                end
            end
        endcase
        if (list_len > max_len_seen) begin
            max_len_seen = list_len;
        end
        res.entry_count = iira_pkg::CNT_OUT_W'(list_len);
        return res;
    endfunction

    // Queues one operation and keeps a running count so that positions can be aimed.
    task automatic queue_list_op(input logic [1:0] opcode, input int pos,
                                 input logic [31:0] value);
        iira_pkg::t_in op;
        op.opcode   = opcode;
        op.position = iira_pkg::POS_W'(pos);
        op.data_in  = value;
        pending_ops.push_back(op);
        case (opcode)
            iira_pkg::OP_APPEND: if (gen_len < iira_pkg::CAPACITY) gen_len++;
            iira_pkg::OP_INSERT: if (pos <= gen_len && gen_len < iira_pkg::CAPACITY) gen_len++;
            iira_pkg::OP_REMOVE: if (gen_len > 0 && pos < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 11))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            3: v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int pick_position(input logic [1:0] opcode);
        int pos;
        if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, 31);
        end else if (opcode == iira_pkg::OP_INSERT) begin
            pos = $urandom_range(0, gen_len);
        end else if (gen_len > 0) begin
            pos = $urandom_range(0, gen_len - 1);
        end else begin
            pos = $urandom_range(0, 31);
        end
        return pos;
    endfunction

    task automatic build_stimulus();
        int made;
        int mode;
        int run_len;
        int r;
        logic [1:0] opcode;
        queue_list_op(iira_pkg::OP_READ,   0,  32'h1234_5678);
        queue_list_op(iira_pkg::OP_REMOVE, 0,  32'h0);
        queue_list_op(iira_pkg::OP_INSERT, 1,  32'h1111_1111);
        queue_list_op(iira_pkg::OP_INSERT, 31, 32'h2222_2222);
        queue_list_op(iira_pkg::OP_INSERT, 0,  32'h8000_0000);
        queue_list_op(iira_pkg::OP_APPEND, 31, 32'h7FFF_FFFF);
        queue_list_op(iira_pkg::OP_APPEND, 0,  32'h0000_0000);
        queue_list_op(iira_pkg::OP_APPEND, 17, 32'hFFFF_FFFF);
        queue_list_op(iira_pkg::OP_INSERT, 4,  32'h5555_5555);
        queue_list_op(iira_pkg::OP_INSERT, 2,  32'hAAAA_AAAA);
        queue_list_op(iira_pkg::OP_READ,   31, 32'h0);
        queue_list_op(iira_pkg::OP_READ,   0,  32'h0);
        queue_list_op(iira_pkg::OP_READ,   5,  32'h0);
        queue_list_op(iira_pkg::OP_REMOVE, 6,  32'h0);
        queue_list_op(iira_pkg::OP_REMOVE, 31, 32'h0);
        queue_list_op(iira_pkg::OP_REMOVE, 2,  32'h0);
        queue_list_op(iira_pkg::OP_REMOVE, 4,  32'h0);
        queue_list_op(iira_pkg::OP_READ,   3,  32'h0);
        queue_list_op(iira_pkg::OP_READ,   4,  32'h0);
        queue_list_op(iira_pkg::OP_APPEND, 0,  32'h0000_FFFF);

        // Runs that mostly grow, mostly shrink or mix, so the list swings between empty and full.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 2);
            run_len = $urandom_range(8, 40);
            repeat (run_len) begin
                r = $urandom_range(0, 99);
                if (mode == 0) begin
                    opcode = (r < 45) ? iira_pkg::OP_APPEND : (r < 80) ? iira_pkg::OP_INSERT :
                             (r < 92) ? iira_pkg::OP_READ : iira_pkg::OP_REMOVE;
                end else if (mode == 1) begin
                    opcode = (r < 70) ? iira_pkg::OP_REMOVE : (r < 85) ? iira_pkg::OP_READ :
                             (r < 93) ? iira_pkg::OP_APPEND : iira_pkg::OP_INSERT;
                end else begin
                    opcode = 2'($urandom_range(0, 3));
                end
                queue_list_op(opcode, pick_position(opcode), pick_value());
                made++;
            end
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_ready  = 1'b0;
        i_data   = '0;
        list_len = 0;
        gen_len  = 0;
        max_len_seen = 0;
        fail_count   = 0;
        report_count = 0;
        ops_taken    = 0;
        results_seen = 0;
        status_seen  = '{default: 0};
        cycle_count  = 0;
        drv_gap = 0;
        snk_gap = 0;
        op_fire = 1'b0;
        for (int k = 0; k < iira_pkg::CAPACITY; k++) begin
            list_words[k] = '0;
        end
        build_stimulus();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d operations and checked %0d results; deepest list held %0d entries.",
                 ops_taken, results_seen, max_len_seen);
        $display("Status seen: ok %0d, bad index %0d, full %0d, empty %0d; %0d failures.",
                 status_seen[iira_pkg::ST_OK], status_seen[iira_pkg::ST_BAD_INDEX],
                 status_seen[iira_pkg::ST_FULL], status_seen[iira_pkg::ST_EMPTY], fail_count);
        if (fail_count == 0) begin
            $display("[indexed_insert_remove_array] OK");
        end else begin
            $display("[indexed_insert_remove_array] ERROR");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("[indexed_insert_remove_array] ERROR");
            $finish;
        end
    end

    // Input side: holds each item until it is taken, with occasional bursts of idle cycles.
    always @(negedge i_clk) begin
        logic next_valid;
        if (i_rst_n && (!i_valid || op_fire)) begin
            next_valid = 1'b0;
            if (drv_gap > 0) begin
                drv_gap--;
            end else if (pending_ops.size() == 0) begin
                next_valid = 1'b0;
            end else if (pending_ops.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
                drv_gap = $urandom_range(1, 7) - 1;
            end else begin
                i_data <= pending_ops.pop_front();
                next_valid = 1'b1;
            end
            i_valid <= next_valid;
        end
    end

    // Output side: stalls in bursts while plenty of stimulus remains.
    always @(negedge i_clk) begin
        if (snk_gap > 0) begin
            snk_gap--;
            i_ready <= 1'b0;
        end else if (pending_ops.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(1, 7) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        iira_pkg::t_out want;
        op_fire = i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            status_seen[o_data.status]++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (report_count < 10) begin
                    report_count++;
                    $display("Unexpected result at cycle %0d: data %0d status %0d count %0d",
                             cycle_count, o_data.data_out, o_data.status,
                             o_data.entry_count);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_data.data_out !== want.data_out || o_data.status !== want.status ||
                    o_data.entry_count !== want.entry_count) begin
                    fail_count++;
                    if (report_count < 10) begin
                        report_count++;
                        $display("Mismatch at cycle %0d: expected data %0d status %0d count %0d",
                                 cycle_count, want.data_out, want.status, want.entry_count);
                        $display("    got data %0d status %0d count %0d",
                                 o_data.data_out, o_data.status, o_data.entry_count);
                    end
                end
            end
        end
        if (op_fire) begin
            ops_taken++;
            expected_results.push_back(apply_list_op(i_data));
        end
    end

endmodule
